>>> design/trrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trrc_pkg
// Shared types and constants of the two-rotor reflector cipher.
// ----------------------------------------------------------------------------
package trrc_pkg;
	localparam int ROTOR_ENTRIES = 64;
	localparam int SYM_W = 6;
	localparam int ROW_LEN = 8;

	typedef logic [SYM_W-1:0] sym_t;

	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_ENCRYPT = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_A,
		ST_READ_B,
		ST_SCAN_B,
		ST_SCAN_A,
		ST_UPDATE,
		ST_OUT
	} state_t;

	// Column source for each permute pattern.
	function automatic logic [2:0] col_src(input logic [2:0] pat, input logic [2:0] c);
		logic [2:0] s;
		s = c;
		case (pat)
			3'd0: s = c;
			3'd1: s = c ^ 3'd1;
			3'd2: s = c ^ 3'd2;
			3'd3: begin
				case (c)
					3'd1: s = 3'd4;
					3'd2: s = 3'd5;
					3'd3: s = 3'd6;
					3'd4: s = 3'd1;
					3'd5: s = 3'd2;
					3'd6: s = 3'd3;
					default: s = c;
				endcase
			end
			3'd4: s = c ^ 3'd4;
			3'd5: begin
				case (c)
					3'd0: s = 3'd5;
					3'd1: s = 3'd6;
					3'd2: s = 3'd7;
					3'd5: s = 3'd0;
					3'd6: s = 3'd1;
					3'd7: s = 3'd2;
					default: s = c;
				endcase
			end
			3'd6: begin
				case (c)
					3'd0: s = 3'd6;
					3'd1: s = 3'd7;
					3'd2: s = 3'd3;
					3'd3: s = 3'd2;
					3'd4: s = 3'd5;
					3'd5: s = 3'd4;
					3'd6: s = 3'd0;
					default: s = 3'd1;
				endcase
			end
			default: s = ~c;
		endcase
		return s;
	endfunction
endpackage
`default_nettype wire

>>> design/trrc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trrc_in_if / trrc_out_if
// Valid/ready channels for requests and cipher results.
// ----------------------------------------------------------------------------
interface trrc_in_if;
	import trrc_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] action;
	sym_t entry_index;
	sym_t entry_value;
	sym_t symbol;
	modport source (output valid, action, entry_index, entry_value, symbol, input ready);
	modport sink (input valid, action, entry_index, entry_value, symbol, output ready);
endinterface

interface trrc_out_if;
	import trrc_pkg::*;
	logic valid;
	logic ready;
	sym_t cipher_symbol;
	modport source (output valid, cipher_symbol, input ready);
	modport sink (input valid, cipher_symbol, output ready);
endinterface
`default_nettype wire

>>> design/two_rotor_reflector_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_rotor_reflector_cipher
// Loads are written into the live bank as they are accepted. An encrypt reads
// A then B, scans B and then A for the inverse lookups, then rewrites both
// rotors into the idle bank; the next request is taken once the result is
// registered. A waiting result holds only the next encrypt at its last step.
// Reset clears control only; rotor contents are undefined.
// ----------------------------------------------------------------------------
module two_rotor_reflector_cipher import trrc_pkg::*; (
	input wire clk,
	input wire arst_n,
	trrc_in_if.sink in_ch,
	trrc_out_if.source out_ch
);
	state_t state_q, state_d;
	logic [5:0] mem_a [ROTOR_ENTRIES];
	logic [5:0] mem_b [ROTOR_ENTRIES];
	sym_t rd_a_q, rd_b_q;
	sym_t ra_addr, rb_addr;
	logic ra_en, rb_en;
	logic [6:0] cnt_q;
	logic scan_v_q;
	sym_t scan_idx_q;
	sym_t sym_q, a_q, b_q, j_q, k_q, out_q;
	logic out_v_q;
	// Updated rotors go to the idle bank; the banks swap after each encrypt.
	logic [5:0] mem_a2 [ROTOR_ENTRIES];
	logic [5:0] mem_b2 [ROTOR_ENTRIES];
	logic bank_q;
	sym_t rd_a2_q, rd_b2_q;
	sym_t a_cur, b_cur;
	sym_t wr_addr_a_q, wr_addr_b_q;

	wire acc_in = in_ch.valid && in_ch.ready;
	wire ld_a = acc_in && in_ch.action == ACT_LOAD_A;
	wire ld_b = acc_in && in_ch.action == ACT_LOAD_B;
	wire upd_wr = state_q == ST_UPDATE && scan_v_q;
	wire res_go = state_q == ST_OUT && !out_v_q;

	assign in_ch.ready = state_q == ST_IDLE;
	assign out_ch.valid = out_v_q;
	assign out_ch.cipher_symbol = out_q;

	// read data from the live bank
	assign a_cur = bank_q ? rd_a2_q : rd_a_q;
	assign b_cur = bank_q ? rd_b2_q : rd_b_q;

	always_comb begin
		ra_addr = sym_q;
		rb_addr = a_cur;
		case (state_q)
			ST_READ_A: ra_addr = sym_q;
			ST_SCAN_B: rb_addr = cnt_q[5:0];
			ST_SCAN_A: ra_addr = cnt_q[5:0];
			ST_UPDATE: begin
				ra_addr = cnt_q[5:0] - {4'd0, a_q[1:0]};
				rb_addr = {cnt_q[5:3], col_src(b_q[2:0], cnt_q[2:0])};
			end
			default: begin
				ra_addr = sym_q;
				rb_addr = a_cur;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_a_q <= mem_a[ra_addr];
		rd_a2_q <= mem_a2[ra_addr];
		rd_b_q <= mem_b[rb_addr];
		rd_b2_q <= mem_b2[rb_addr];
		wr_addr_a_q <= ra_addr + {4'd0, a_q[1:0]};
		wr_addr_b_q <= cnt_q[5:0];
		if ((ld_a && !bank_q) || (upd_wr && bank_q))
			mem_a[ld_a ? in_ch.entry_index : wr_addr_a_q] <= ld_a ? in_ch.entry_value : a_cur;
		if ((ld_a && bank_q) || (upd_wr && !bank_q))
			mem_a2[ld_a ? in_ch.entry_index : wr_addr_a_q] <= ld_a ? in_ch.entry_value : a_cur;
		if ((ld_b && !bank_q) || (upd_wr && bank_q))
			mem_b[ld_b ? in_ch.entry_index : wr_addr_b_q] <= ld_b ? in_ch.entry_value : b_cur;
		if ((ld_b && bank_q) || (upd_wr && !bank_q))
			mem_b2[ld_b ? in_ch.entry_index : wr_addr_b_q] <= ld_b ? in_ch.entry_value : b_cur;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc_in && in_ch.action == ACT_ENCRYPT) state_d = ST_READ_A;
			ST_READ_A: state_d = ST_READ_B;
			ST_READ_B: state_d = ST_SCAN_B;
			ST_SCAN_B: if (cnt_q == 7'd64) state_d = ST_SCAN_A;
			ST_SCAN_A: if (cnt_q == 7'd64) state_d = ST_UPDATE;
			ST_UPDATE: if (cnt_q == 7'd64) state_d = ST_OUT;
			ST_OUT: if (!out_v_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			bank_q <= 1'b0;
			cnt_q <= '0;
			scan_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			if (res_go) begin
				out_v_q <= 1'b1;
				bank_q <= ~bank_q;
			end
			scan_v_q <= (state_q == ST_SCAN_B || state_q == ST_SCAN_A ||
				state_q == ST_UPDATE) && cnt_q != 7'd64;
			if (state_d != state_q) cnt_q <= '0;
			else if (cnt_q != 7'd64) cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_q <= cnt_q[5:0];
		if (acc_in) sym_q <= in_ch.symbol;
		if (state_q == ST_READ_B) a_q <= a_cur;
		if (state_q == ST_SCAN_B && cnt_q == 7'd0) begin
			b_q <= b_cur;
			j_q <= '0;
			k_q <= '0;
		end
		if (state_q == ST_SCAN_B && scan_v_q && b_cur == ~b_q) j_q <= scan_idx_q;
		if (state_q == ST_SCAN_A && scan_v_q && a_cur == j_q) k_q <= scan_idx_q;
		if (res_go) out_q <= k_q;
	end

	// output only changes when loaded
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.cipher_symbol))
		else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready)
		else $error("accepted while busy");
	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && !out_v_q |=> bank_q != $past(bank_q))
		else $error("bank not swapped");
endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the two-rotor reflector cipher: rotor loads and symbol encryption
// are predicted in a scoreboard and every cipher result is compared in order.
// ----------------------------------------------------------------------------

class cipher_scoreboard;
	logic [5:0] rotor_a [64];
	logic [5:0] rotor_b [64];
	logic [5:0] cipher_q [$];
	int mismatches;

	function new();
		mismatches = 0;
		foreach (rotor_a[i]) begin
			rotor_a[i] = 6'd0;
			rotor_b[i] = 6'd0;
		end
	endfunction

	function logic [5:0] find_pos(input logic [5:0] rot [64], input logic [5:0] v);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 0; i < 64; i++)
			if (rot[i] == v)
				p = i[5:0];
		return p;
	endfunction

	function logic [2:0] src_col(input logic [2:0] pat, input logic [2:0] c);
		int tbl [8][8];
		tbl = '{'{0,1,2,3,4,5,6,7}, '{1,0,3,2,5,4,7,6}, '{2,3,0,1,6,7,4,5},
			'{0,4,5,6,1,2,3,7}, '{4,5,6,7,0,1,2,3}, '{5,6,7,3,4,0,1,2},
			'{6,7,3,2,5,4,0,1}, '{7,6,5,4,3,2,1,0}};
		return 3'(tbl[pat][c]);
	endfunction

	function void note_request(input trrc_pkg::action_t act, input logic [5:0] idx,
			input logic [5:0] val, input logic [5:0] sym);
		logic [5:0] a, b, r, j, k;
		logic [5:0] tmp [64];
		case (act)
			trrc_pkg::ACT_LOAD_A: rotor_a[idx] = val;
			trrc_pkg::ACT_LOAD_B: rotor_b[idx] = val;
			trrc_pkg::ACT_ENCRYPT: begin
				a = rotor_a[sym];
				b = rotor_b[a];
				r = 6'd63 - b;
				j = find_pos(rotor_b, r);
				k = find_pos(rotor_a, j);
				cipher_q.insert(cipher_q.size(), k);
				for (int i = 0; i < 64; i++)
					tmp[6'(i + a[1:0])] = rotor_a[i];
				rotor_a = tmp;
				for (int i = 0; i < 64; i++)
					tmp[i] = rotor_b[{i[5:3], src_col(b[2:0], i[2:0])}];
				rotor_b = tmp;
			end
			default: ;
		endcase
	endfunction

	function void check_result(input logic [5:0] got);
		logic [5:0] want;
		if (cipher_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %0d", got);
			return;
		end
		want = cipher_q.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("cipher_symbol mismatch: expected %0d got %0d", want, got);
		end
	endfunction
endclass

module tb;
	import trrc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	trrc_in_if in_ch();
	trrc_out_if out_ch();
	cipher_scoreboard sb = new();
	int burst_left = 0;
	bit stall_off = 0;

	two_rotor_reflector_cipher u_top (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = ACT_NONE;
		in_ch.entry_index = '0;
		in_ch.entry_value = '0;
		in_ch.symbol = '0;
		out_ch.ready = 1'b0;
	end

	// receiver stall pattern: runs of ready and stall of random length
	initial begin
		int run;
		@(negedge clk);
		forever begin
			run = $urandom_range(1, 30);
			out_ch.ready <= stall_off ? 1'b1 : ~out_ch.ready;
			repeat (run) @(negedge clk);
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.cipher_symbol);

	// called at a falling edge; valid stays high inside a burst
	task automatic send_request(input action_t act, input logic [5:0] idx,
			input logic [5:0] val, input logic [5:0] sym);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.entry_index <= idx;
		in_ch.entry_value <= val;
		in_ch.symbol <= sym;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(act, idx, val, sym);
		@(negedge clk);
	endtask

	task automatic load_rotors(input bit raw);
		int perm [64];
		foreach (perm[i]) perm[i] = i;
		perm.shuffle();
		for (int i = 0; i < 64; i++)
			send_request(ACT_LOAD_A, i[5:0],
				raw ? 6'($urandom_range(0, 63)) : perm[i][5:0], 6'(i));
		perm.shuffle();
		for (int i = 0; i < 64; i++)
			send_request(ACT_LOAD_B, i[5:0],
				raw ? 6'($urandom_range(0, 63)) : perm[i][5:0], 6'(~i));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.cipher_q.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	initial begin
		int n;
		int op;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed: identity rotor A, reversed rotor B, extremes, unused action
		for (int i = 0; i < 64; i++) send_request(ACT_LOAD_A, i[5:0], i[5:0], 6'd63);
		for (int i = 0; i < 64; i++) send_request(ACT_LOAD_B, i[5:0], 6'(63 - i), 6'd0);
		send_request(ACT_ENCRYPT, 6'd63, 6'd0, 6'd0);
		send_request(ACT_ENCRYPT, 6'd0, 6'd63, 6'd63);
		send_request(ACT_NONE, 6'd0, 6'd63, 6'd21);
		for (int i = 0; i < 8; i++) send_request(ACT_ENCRYPT, 6'd42, 6'd21, 6'(i * 9));
		// non-permutation: duplicates and missing values
		send_request(ACT_LOAD_B, 6'd5, 6'd0, 6'd0);
		send_request(ACT_LOAD_A, 6'd9, 6'd63, 6'd0);
		send_request(ACT_ENCRYPT, 6'd0, 6'd0, 6'd9);
		send_request(ACT_ENCRYPT, 6'd0, 6'd0, 6'd42);
		drain();
		stall_off = 1;
		n = 0;
		while (n < 1700) begin
			if (n % 300 == 0) begin
				load_rotors(n % 600 == 300);
				n += 128;
			end
			op = $urandom_range(0, 19);
			if (op == 0)
				send_request(ACT_LOAD_A, 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			else if (op == 1)
				send_request(ACT_LOAD_B, 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			else if (op == 2)
				send_request(ACT_NONE, 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			else
				send_request(ACT_ENCRYPT, 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			if (n == 800) begin
				stall_off = 0;
				drain();
			end
			n++;
		end
		drain();
		if (sb.mismatches == 0 && sb.cipher_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end
endmodule
